// ===== src/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants for the motor pulse-density drive: protocol
// codes, field widths and the per-period servo information record.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned SERVO_W  = 8;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned DRIVE_W  = 6;
  localparam int unsigned TDATA_W  = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command byte that opens a set-motors frame
  localparam logic [BYTE_W-1:0] CMD_OPEN_FRAME = 8'h40;

  // Speed that means stop, and the modulator thresholds
  localparam logic [ACC_W-1:0]        STOP_LEVEL_U = 16'd127;
  localparam logic signed [ACC_W-1:0] STOP_LEVEL   = 16'sd127;
  localparam logic signed [ACC_W-1:0] STOP_LEVEL_N = -16'sd127;

  // Servo data and frame flag carried with each control period
  typedef struct packed {
    logic               frame_done;
    logic [SERVO_W-1:0] servo_one;
    logic [SERVO_W-1:0] servo_zero;
  } period_info_t;

endpackage

// ===== src/mpd_front.sv =====
// ----------------------------------------------------------------------------
// mpd_front
// Byte parser: tracks the frame position, latches motor speeds and servo
// positions, and issues one control-period record per period-ending byte.
// ----------------------------------------------------------------------------
module mpd_front #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   byte_valid,
  input  logic [mpd_pkg::BYTE_W-1:0]             byte_data,
  output logic                                   push,
  output logic [NUM_CHANNELS*mpd_pkg::SPEED_W-1:0] push_speeds,
  output mpd_pkg::period_info_t                  push_info
);
  import mpd_pkg::*;

  localparam int unsigned LAST_POS = NUM_CHANNELS + 1;
  localparam int unsigned POS_W    = $clog2(NUM_CHANNELS + 3);

  logic [POS_W-1:0]   frame_position;
  logic [SPEED_W-1:0] motor_speed [NUM_CHANNELS];
  logic [SERVO_W-1:0] servo_position [2];
  logic [SERVO_W-1:0] pending_servo_zero;

  logic is_idle;
  logic is_last;

  assign is_idle = (frame_position == '0);
  assign is_last = (frame_position == POS_W'(LAST_POS + 1));

  // Issue a period record for a plain byte outside a frame or a frame's last byte
  always_comb begin
    push = byte_valid && ((is_idle && (byte_data != CMD_OPEN_FRAME)) || is_last);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      push_speeds[c*SPEED_W +: SPEED_W] = motor_speed[c];
    end
    push_info.frame_done = is_last;
    push_info.servo_zero = is_last ? servo_position[0] : '0;
    push_info.servo_one  = is_last ? servo_position[1] : '0;
  end

  // Advance the frame position and hold the frame data
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position     <= '0;
      pending_servo_zero <= '0;
      servo_position[0]  <= '0;
      servo_position[1]  <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        motor_speed[c] <= '0;
      end
    end else if (byte_valid) begin
      if (is_idle) begin
        if (byte_data == CMD_OPEN_FRAME) begin
          frame_position <= POS_W'(1);
        end
      end else if (is_last) begin
        frame_position    <= '0;
        servo_position[0] <= pending_servo_zero;
        servo_position[1] <= byte_data;
      end else begin
        frame_position <= frame_position + POS_W'(1);
        if (frame_position == POS_W'(LAST_POS)) begin
          pending_servo_zero <= byte_data;
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (frame_position == POS_W'(c + 1)) begin
            motor_speed[c] <= byte_data;
          end
        end
      end
    end
  end

endmodule

// ===== src/mpd_queue.sv =====
// ----------------------------------------------------------------------------
// mpd_queue
// Short register queue that decouples the byte parser from the modulator.
// ----------------------------------------------------------------------------
module mpd_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import mpd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/mpd_back.sv =====
// ----------------------------------------------------------------------------
// mpd_back
// Delta-sigma modulator bank: one 16-bit accumulator per channel, updated
// once per control period, with a registered result stage.
// ----------------------------------------------------------------------------
module mpd_back #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  input  logic [NUM_CHANNELS*mpd_pkg::SPEED_W-1:0] q_speeds,
  input  mpd_pkg::period_info_t                    q_info,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [mpd_pkg::DRIVE_W-1:0]              out_drive,
  output mpd_pkg::period_info_t                    out_info
);
  import mpd_pkg::*;

  localparam int unsigned ALL_W = 2 * NUM_CHANNELS;

  logic [ACC_W-1:0]        channel_accumulator [NUM_CHANNELS];
  logic [ACC_W-1:0]        acc_next [NUM_CHANNELS];
  logic [ALL_W-1:0]        bits_all;
  logic signed [ACC_W-1:0] sum [NUM_CHANNELS];

  // Take a record when the result stage is free or being drained
  assign q_pop = !q_empty && (!out_valid || out_ready);

  // Update every channel in parallel
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      sum[c] = $signed(channel_accumulator[c]
                       + {{(ACC_W-SPEED_W){1'b0}}, q_speeds[c*SPEED_W +: SPEED_W]}
                       - STOP_LEVEL_U);
      bits_all[2*c]   = 1'b0;
      bits_all[2*c+1] = 1'b0;
      if (sum[c] >= STOP_LEVEL) begin
        acc_next[c]   = sum[c] - STOP_LEVEL;
        bits_all[2*c] = 1'b1;
      end else if (sum[c] < STOP_LEVEL_N) begin
        acc_next[c]     = sum[c] + STOP_LEVEL;
        bits_all[2*c+1] = 1'b1;
      end else begin
        acc_next[c] = sum[c];
      end
    end
  end

  // Hold accumulators and the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        channel_accumulator[c] <= '0;
      end
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          channel_accumulator[c] <= acc_next[c];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load result payload; channels beyond the drive field are dropped
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_drive <= DRIVE_W'({{DRIVE_W{1'b0}}, bits_all});
      out_info  <= q_info;
    end
  end

endmodule

// ===== src/three_channel_motor_pulse_density_drive.sv =====
// ----------------------------------------------------------------------------
// three_channel_motor_pulse_density_drive
// Byte-protocol front end feeding a bank of first-order delta-sigma
// pulse-density modulators for the motor channels, plus servo pass-out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | rx_byte[7:0]                                | -
//  m_axis  | out | drive_bits[5:0], servo_pulse_zero[13:6],    | frame_done
//          |     | servo_pulse_one[21:14], zero pad [23:22]    |
//
// One byte is accepted per cycle while s_tready is high. A byte that ends a
// control period is stored as a record in the queue on acceptance, and the
// modulator stage loads it from there once its result stage is free or drained.
// rst clears the frame position, speeds, servo values, accumulators and queue.
// A stalled m_axis fills the two-entry queue; s_tready drops only when full.
// ----------------------------------------------------------------------------
module three_channel_motor_pulse_density_drive #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mpd_pkg::TDATA_W-1:0]  m_tdata,   // [5:0] drive_bits,
                                                  // [13:6] servo_pulse_zero,
                                                  // [21:14] servo_pulse_one,
                                                  // [23:22] zero
  output logic                         m_tuser    // [0] frame_done
);
  import mpd_pkg::*;

  localparam int unsigned SPEEDS_W = NUM_CHANNELS * SPEED_W;
  localparam int unsigned ENTRY_W  = SPEEDS_W + $bits(period_info_t);

  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  logic [SPEEDS_W-1:0] push_speeds;
  period_info_t        push_info;
  logic [ENTRY_W-1:0]  q_rd_data;
  logic [DRIVE_W-1:0]  out_drive;
  period_info_t        out_info;
  period_info_t        q_info;

  assign s_tready = !q_full;

  // Parse bytes
  mpd_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (s_tvalid && s_tready),
    .byte_data   (s_tdata),
    .push        (q_push),
    .push_speeds (push_speeds),
    .push_info   (push_info)
  );

  // Buffer control-period records
  mpd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data ({push_info, push_speeds}),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign q_info = q_rd_data[ENTRY_W-1:SPEEDS_W];

  // Run the modulators
  mpd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_speeds  (q_rd_data[SPEEDS_W-1:0]),
    .q_info    (q_info),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_drive (out_drive),
    .out_info  (out_info)
  );

  // Pack the result
  assign m_tdata = {2'b00, out_info.servo_one, out_info.servo_zero, out_drive};
  assign m_tuser = out_info.frame_done;

endmodule

// ===== src/mpd_checker.sv =====
// ----------------------------------------------------------------------------
// mpd_checker
// Port-level checks for the motor pulse-density drive, bound to the top.
// ----------------------------------------------------------------------------
module mpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Accept input right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // Servo fields and padding are zero on a period outside a frame
  a_servo_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[23:6] == 18'd0))
    else $error("servo fields set on a period outside a frame");

  // A channel never drives forward and reverse at once
  a_no_shoot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (((m_tdata[0] & m_tdata[1]) | (m_tdata[2] & m_tdata[3])
                   | (m_tdata[4] & m_tdata[5])) == 1'b0))
    else $error("forward and reverse set on one channel");

endmodule

bind three_channel_motor_pulse_density_drive mpd_checker u_mpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
